@@ sv/twtd_pkg.sv @@
package twtd_pkg;

	// Character and key code bounds
	localparam logic [7:0] CH_A         = 8'h41;
	localparam logic [7:0] CH_Z         = 8'h5A;
	localparam logic [7:0] CH_0         = 8'h30;
	localparam logic [7:0] CH_9         = 8'h39;
	localparam logic [7:0] VK_PAD_FIRST = 8'h60;
	localparam logic [7:0] VK_PAD_LAST  = 8'h69;
	localparam logic [7:0] CH_NONE      = 8'h00;

	// Message kinds
	localparam logic [1:0] KIND_KEYDOWN    = 2'd0;
	localparam logic [1:0] KIND_SYSKEYDOWN = 2'd1;

	// Request functions
	localparam logic FUNC_KEY     = 1'b0;
	localparam logic FUNC_CONSUME = 1'b1;

	// Configuration register map
	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 64;
	localparam int LEN_W      = 5;
	localparam int WORD_BYTES = 32;
	localparam logic [REG_IDX_W-1:0] REG_WORD_LENGTH   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WORD_LOW      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WORD_MID_LOW  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WORD_MID_HIGH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WORD_HIGH     = 3'd4;

	typedef struct packed {
		logic        func;
		logic [1:0]  msg_kind;
		logic        auto_repeat;
		logic [7:0]  virtual_key;
		logic [31:0] event_time;
	} in_item_t;

	typedef struct packed {
		logic key_counted;
		logic matched;
		logic pending_flag;
	} out_item_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic        consume;
		logic        candidate;
		logic [7:0]  ch;
		logic [7:0]  virtual_key;
		logic [31:0] event_time;
	} cls_item_t;

endpackage

@@ sv/twtd_fifo.sv @@
module twtd_fifo
	import twtd_pkg::*;
#(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output item_t dout,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/twtd_front.sv @@
module twtd_front
	import twtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  item,
	output logic      full,
	output logic      cls_push,
	output cls_item_t cls_item,
	input  logic      cls_full
);

	logic      valid_s1;
	cls_item_t item_s1;
	cls_item_t cls_d;
	logic      take;
	logic      kind_ok;

	// Map the key code to a history character; CH_NONE if it does not map
	always_comb begin
		cls_d.consume     = (item.func == FUNC_CONSUME);
		cls_d.virtual_key = item.virtual_key;
		cls_d.event_time  = item.event_time;
		if (item.virtual_key inside {[CH_A:CH_Z], [CH_0:CH_9]}) begin
			cls_d.ch = item.virtual_key;
		end else if (item.virtual_key inside {[VK_PAD_FIRST:VK_PAD_LAST]}) begin
			cls_d.ch = CH_0 + (item.virtual_key - VK_PAD_FIRST);
		end else begin
			cls_d.ch = CH_NONE;
		end
		kind_ok = (item.msg_kind == KIND_KEYDOWN) || (item.msg_kind == KIND_SYSKEYDOWN);
		cls_d.candidate = !cls_d.consume && kind_ok && !item.auto_repeat &&
			(cls_d.ch != CH_NONE);
	end

	assign cls_push = valid_s1 && !cls_full;
	assign cls_item = item_s1;
	assign full     = valid_s1 && cls_full;
	assign take     = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cls_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls_d;
		end
	end

endmodule

@@ sv/twtd_back.sv @@
module twtd_back
	import twtd_pkg::*;
#(
	parameter int WORD_CAPACITY = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	input  logic                  cls_empty,
	input  cls_item_t             cls_item,
	output logic                  cls_pop,
	output logic                  res_push,
	output out_item_t             res_item,
	input  logic                  res_full
);

	localparam int HIST_DEPTH = WORD_CAPACITY - 1;
	localparam int CNT_W      = $clog2(WORD_CAPACITY);

	logic [LEN_W-1:0]      word_len_q;
	logic [REG_DATA_W-1:0] word_q [4];
	logic [7:0]            hist_q [HIST_DEPTH];
	logic [CNT_W-1:0]      hist_cnt_q;
	logic [7:0]            last_code_q;
	logic [31:0]           last_time_q;
	logic                  pending_q;

	logic [8*WORD_BYTES-1:0] word_flat;
	logic [7:0]              hist_new [HIST_DEPTH];
	logic [CNT_W-1:0]        cnt_new;
	logic [LEN_W-1:0]        byte_idx;
	logic                    fire;
	logic                    counted;
	logic                    mismatch;
	logic                    hit;

	assign word_flat = {word_q[3], word_q[2], word_q[1], word_q[0]};
	assign fire      = !cls_empty && !res_full;
	assign cls_pop   = fire;
	assign res_push  = fire;
	assign counted   = cls_item.candidate &&
		!((cls_item.event_time == last_time_q) && (cls_item.virtual_key == last_code_q));

	// Newest character at entry 0; the oldest falls off the far end
	always_comb begin
		hist_new[0] = cls_item.ch;
		for (int j = 1; j < HIST_DEPTH; j++) begin
			hist_new[j] = hist_q[j-1];
		end
		cnt_new = (hist_cnt_q == CNT_W'(HIST_DEPTH)) ? hist_cnt_q : hist_cnt_q + 1'b1;
	end

	// Entry j of the history lines up with word byte len-1-j
	always_comb begin
		mismatch = 1'b0;
		byte_idx = '0;
		for (int j = 0; j < HIST_DEPTH; j++) begin
			byte_idx = word_len_q - LEN_W'(j) - 1'b1;
			if ((LEN_W'(j) < word_len_q) && (hist_new[j] != word_flat[8*byte_idx +: 8])) begin
				mismatch = 1'b1;
			end
		end
		hit = counted && (word_len_q != '0) &&
			((LEN_W + 1)'(word_len_q) <= (LEN_W + 1)'(cnt_new)) && !mismatch;
	end

	always_comb begin
		res_item.key_counted = 1'b0;
		res_item.matched     = 1'b0;
		res_item.pending_flag = pending_q;
		if (!cls_item.consume) begin
			res_item.key_counted  = counted;
			res_item.matched      = hit;
			res_item.pending_flag = pending_q || hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q  <= '0;
			word_q[0]   <= '0;
			word_q[1]   <= '0;
			word_q[2]   <= '0;
			word_q[3]   <= '0;
			hist_cnt_q  <= '0;
			last_code_q <= '0;
			last_time_q <= '0;
			pending_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_WORD_LENGTH: begin
						word_len_q <= wr_data[LEN_W-1:0];
						hist_cnt_q <= '0;
					end
					REG_WORD_LOW: begin
						word_q[0]  <= wr_data;
						hist_cnt_q <= '0;
					end
					REG_WORD_MID_LOW: begin
						word_q[1]  <= wr_data;
						hist_cnt_q <= '0;
					end
					REG_WORD_MID_HIGH: begin
						word_q[2]  <= wr_data;
						hist_cnt_q <= '0;
					end
					REG_WORD_HIGH: begin
						word_q[3]  <= wr_data;
						hist_cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (fire) begin
				if (cls_item.consume) begin
					pending_q <= 1'b0;
				end else if (counted) begin
					last_code_q <= cls_item.virtual_key;
					last_time_q <= cls_item.event_time;
					hist_cnt_q  <= hit ? '0 : cnt_new;
					if (hit) begin
						pending_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && counted) begin
			for (int j = 0; j < HIST_DEPTH; j++) begin
				hist_q[j] <= hist_new[j];
			end
		end
	end

endmodule

@@ sv/typed_word_tail_detector.sv @@
// Typed word tail detector.
// Input channel: a request is transferred on a rising edge with push high and
// full low. A key event (func clear) carries message kind, auto-repeat bit,
// key code and time stamp; a consume request (func set) reads and clears the
// sticky pending flag.
// Result channel: one result per request, in request order. The oldest result
// sits on result while empty is low and is transferred when pop is high.
// Configuration: wr_en/wr_index/wr_data write the word length or one of the
// four word character registers; a write empties the history unless a counted
// key executes with it. Path: classify register, queue in front of the execute
// step, then the execute step into the result queue.
// Throughput: one request per cycle while the receiver pops; the execute step
// does the history update, the duplicate check and the full tail compare at once.
// Stalls: a receiver that stops popping fills the 2-entry result queue, then
// the 2-entry queue in front of the execute step, then raises full; nothing
// is dropped. Reset clears history, flag, last key and word registers.
module typed_word_tail_detector
	import twtd_pkg::*;
#(
	parameter int WORD_CAPACITY = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              item,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             result,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data
);

	// Front to back hand-off
	logic      cls_push;
	logic      cls_full;
	cls_item_t cls_in;
	logic      cls_pop;
	logic      cls_empty;
	cls_item_t cls_out;

	// Back to result queue
	logic      res_push;
	logic      res_full;
	out_item_t res_in;

	twtd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cls_push (cls_push),
		.cls_item (cls_in),
		.cls_full (cls_full)
	);

	twtd_fifo #(
		.item_t (cls_item_t),
		.DEPTH  (2)
	) u_cls_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cls_push),
		.din    (cls_in),
		.full   (cls_full),
		.pop    (cls_pop),
		.dout   (cls_out),
		.empty  (cls_empty)
	);

	twtd_back #(
		.WORD_CAPACITY (WORD_CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cls_empty (cls_empty),
		.cls_item  (cls_out),
		.cls_pop   (cls_pop),
		.res_push  (res_push),
		.res_item  (res_in),
		.res_full  (res_full)
	);

	// Result queue parts the execute step from the receiver
	twtd_fifo #(
		.item_t (out_item_t),
		.DEPTH  (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule
